### design/timed_command_queue_assert.svh
// Assertion macros used by the timed command queue back end.
`ifndef TIMED_COMMAND_QUEUE_ASSERT_SVH
`define TIMED_COMMAND_QUEUE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TCQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define TCQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/tcq_pkg.sv
`default_nettype none
package tcq_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COMMAND_KINDS_DEF = 256;
    localparam int TIME_FRAC_BITS_DEF = 16;
    localparam int TIME_W = 32;
    localparam int CMD_W = 8;
    localparam int PAY_W = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0, OP_FLUSH = 2'd1, OP_ADVANCE = 2'd2, OP_SET = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_ACK = 2'd0, ST_FULL = 2'd1, ST_DISPATCH = 2'd2, ST_NONE = 2'd3
    } t_status;

    // classified request handed from front to back
    typedef struct packed {
        t_op               op;
        logic [TIME_W-1:0] tval;
        logic [CMD_W-1:0]  cmd;
        logic [PAY_W-1:0]  pay;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [CMD_W-1:0]  cmd;
        logic [PAY_W-1:0]  pay;
        logic [TIME_W-1:0] due;
        logic              last;
    } t_rsp;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {a[TIME_W-1], a} + {b[TIME_W-1], b};
        if (s[TIME_W] != s[TIME_W-1])
            return s[TIME_W] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
        return s[TIME_W-1:0];
    endfunction

    // a + diff where diff is 33-bit exact
    function automatic logic [TIME_W-1:0] sat_add33(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W:0] d);
        logic [TIME_W+1:0] s;
        s = {{2{a[TIME_W-1]}}, a} + {d[TIME_W], d};
        if (s[TIME_W+1] != s[TIME_W-1] || s[TIME_W] != s[TIME_W-1])
            return s[TIME_W+1] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};
        return s[TIME_W-1:0];
    endfunction
endpackage
`default_nettype wire

### design/tcq_if.sv
`default_nettype none
interface tcq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] time_value;
    logic [7:0]  command_code;
    logic [31:0] payload;
    modport source (output valid, operation, time_value, command_code, payload, input ready);
    modport sink (input valid, operation, time_value, command_code, payload, output ready);
endinterface

interface tcq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  out_command;
    logic [31:0] out_payload;
    logic [31:0] due_time;
    logic        last;
    modport source (output valid, status, out_command, out_payload, due_time, last,
                    input ready);
    modport sink (input valid, status, out_command, out_payload, due_time, last,
                  output ready);
endinterface
`default_nettype wire

### design/tcq_front.sv
`default_nettype none
// Accept requests into a two-entry queue.
module tcq_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    tcq_req_if.sink         req,
    input  wire             i_pop,
    output tcq_pkg::t_req   o_req,
    output logic            o_valid
);
    import tcq_pkg::*;
    t_req       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push;

    assign req.ready = (r_cnt != 2'd2);
    assign push      = req.valid && req.ready;
    assign o_valid   = (r_cnt != 2'd0);
    assign o_req     = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push)
            r_q[r_rd ^ r_cnt[0]] <= '{op: t_op'(req.operation), tval: req.time_value,
                                      cmd: req.command_code, pay: req.payload};
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
        end else begin
            if (i_pop && o_valid)
                r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop && o_valid};
        end
    end
endmodule
`default_nettype wire

### design/tcq_back.sv
`default_nettype none
`include "timed_command_queue_assert.svh"
// Shift-register sorted queue; at most one result per cycle, stalled while the receiver is not ready.
module tcq_back #(
    parameter int QUEUE_DEPTH = tcq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  tcq_pkg::t_req   i_req,
    input  wire             i_valid,
    output logic            o_pop,
    tcq_rsp_if.source       rsp
);
    import tcq_pkg::*;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_DISP, S_OUT} t_state;

    logic [TIME_W-1:0] r_time [QUEUE_DEPTH];
    logic [CMD_W-1:0]  r_cmd  [QUEUE_DEPTH];
    logic [PAY_W-1:0]  r_pay  [QUEUE_DEPTH];
    logic [CW-1:0]     r_used;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_end;
    t_state            r_state;
    t_rsp              r_rsp;
    logic              r_ovalid;

    logic [TIME_W-1:0] due_add;
    logic [TIME_W:0]   diff;
    logic [QUEUE_DEPTH-1:0] le;
    logic              head_due, next_due;
    logic              out_free;
    logic              add_full;

    assign out_free = !r_ovalid || rsp.ready;
    assign due_add  = sat_add(r_now, i_req.tval);
    assign diff     = {i_req.tval[TIME_W-1], i_req.tval} - {r_now[TIME_W-1], r_now};
    assign o_pop    = (r_state == S_IDLE) && i_valid && out_free;
    assign add_full = (i_req.op == OP_ADD) && (r_used == CW'(QUEUE_DEPTH));

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            le[i] = ($signed(r_time[i]) <= $signed(due_add)) && (CW'(i) < r_used);
    end

    assign head_due = (r_used != '0) && ($signed(r_time[0]) <= $signed(r_end));
    assign next_due = (r_used > CW'(1)) && ($signed(r_time[1]) <= $signed(r_end));

    assign rsp.valid       = r_ovalid;
    assign rsp.status      = r_rsp.status;
    assign rsp.out_command = r_rsp.cmd;
    assign rsp.out_payload = r_rsp.pay;
    assign rsp.due_time    = r_rsp.due;
    assign rsp.last        = r_rsp.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_now    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && rsp.ready)
                r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_pop) begin
                    r_rsp <= '{status: add_full ? ST_FULL : ST_ACK, cmd: '0, pay: '0,
                               due: '0, last: 1'b1};
                    unique case (i_req.op)
                        OP_ADD: begin
                            if (!add_full) begin
                                // entry i takes the new request at the first slot
                                // past the equal-or-earlier prefix, else shifts up
                                if (!le[0]) begin
                                    r_time[0] <= due_add;
                                    r_cmd[0]  <= i_req.cmd;
                                    r_pay[0]  <= i_req.pay;
                                end
                                for (int i = 1; i < QUEUE_DEPTH; i++) begin
                                    if (!le[i]) begin
                                        if (le[i-1]) begin
                                            r_time[i] <= due_add;
                                            r_cmd[i]  <= i_req.cmd;
                                            r_pay[i]  <= i_req.pay;
                                        end else begin
                                            r_time[i] <= r_time[i-1];
                                            r_cmd[i]  <= r_cmd[i-1];
                                            r_pay[i]  <= r_pay[i-1];
                                        end
                                    end
                                end
                                r_used <= r_used + CW'(1);
                            end
                            r_ovalid <= 1'b1;
                        end
                        OP_FLUSH: begin
                            r_used   <= '0;
                            r_ovalid <= 1'b1;
                        end
                        OP_SET: begin
                            for (int i = 0; i < QUEUE_DEPTH; i++)
                                r_time[i] <= sat_add33(r_time[i], diff);
                            r_now    <= i_req.tval;
                            r_ovalid <= 1'b1;
                        end
                        OP_ADVANCE: begin
                            r_end   <= due_add;
                            r_now   <= due_add;
                            r_state <= S_DISP;
                        end
                        default: ;
                    endcase
                end
                S_DISP: if (out_free) begin
                    // first look: nothing due gives a single result
                    r_ovalid <= 1'b1;
                    if (!head_due) begin
                        r_rsp   <= '{status: ST_NONE, cmd: '0, pay: '0, due: '0, last: 1'b1};
                        r_state <= S_IDLE;
                    end else begin
                        r_rsp   <= '{status: ST_DISPATCH, cmd: r_cmd[0], pay: r_pay[0],
                                     due: r_time[0], last: !next_due};
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                            r_time[i] <= r_time[i+1];
                            r_cmd[i]  <= r_cmd[i+1];
                            r_pay[i]  <= r_pay[i+1];
                        end
                        r_used  <= r_used - CW'(1);
                        r_state <= next_due ? S_OUT : S_IDLE;
                    end
                end
                S_OUT: if (out_free) begin
                    r_ovalid <= 1'b1;
                    r_rsp    <= '{status: ST_DISPATCH, cmd: r_cmd[0], pay: r_pay[0],
                                  due: r_time[0], last: !next_due};
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        r_time[i] <= r_time[i+1];
                        r_cmd[i]  <= r_cmd[i+1];
                        r_pay[i]  <= r_pay[i+1];
                    end
                    r_used  <= r_used - CW'(1);
                    r_state <= next_due ? S_OUT : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TCQ_ASSERT_IMP(a_used_max, i_clk, i_rst_n, 1'b1, r_used <= CW'(QUEUE_DEPTH))
    `TCQ_ASSERT_IMP(a_out_state, i_clk, i_rst_n, r_state == S_OUT, head_due)
    `TCQ_ASSERT_NEXT(a_pop_idle, i_clk, i_rst_n, o_pop && i_req.op != OP_ADVANCE,
                     r_ovalid && r_rsp.last)
endmodule
`default_nettype wire

### design/timed_command_queue.sv
`default_nettype none
// Timed command queue: pending commands kept sorted by Q16.16 due time.
// Request channel (req): operation, time_value, command_code, payload with
// valid/ready; a request is taken when both are high. Response channel
// (rsp): status, out_command, out_payload, due_time, last with valid/ready.
// Add, flush and set each give one response with last set; advance gives one
// response per due entry (last on the final) or one "nothing due" response.
// A request is written into a two-entry front queue and passes to the back end
// once the back end is idle and its output register is free; add, flush and
// set respond in the cycle after the back end takes them, advance through the
// dispatch state. Add, flush and set sustain one request per cycle while the
// receiver is ready; advance holds the back end's single-issue sequencer in the
// dispatch state, and in the output state for each further due entry.
// Reset clears the entry count and the current time; stored entries are not
// cleared. A stalled receiver holds the output register and the back end
// waits; the front queue keeps taking requests until its two entries fill.
module timed_command_queue #(
    parameter int QUEUE_DEPTH = tcq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tcq_req_if.sink    req,
    tcq_rsp_if.source  rsp
);
    import tcq_pkg::*;
    t_req q_req;
    logic q_valid;
    logic q_pop;

    tcq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req),
        .i_pop(q_pop), .o_req(q_req), .o_valid(q_valid)
    );

    tcq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(q_req), .i_valid(q_valid),
        .o_pop(q_pop), .rsp(rsp)
    );
endmodule
`default_nettype wire
